// ----- hw/rtl/pra_pkg.sv -----
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types and constants for the rolling-average pressure front end.
// ----------------------------------------------------------------------------
package pra_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int MAX_WINDOW  = 32;
    localparam int SLOT_W      = 5;
    localparam int CNT_W       = 6;
    localparam int SUM_W       = 15;
    localparam int AVG_FRAC    = 4;
    localparam int AVG_W       = 14;
    localparam int PRESS_W     = 19;
    localparam int WIN_W       = 6;
    localparam int MODEL_W     = 2;
    localparam int REF_W       = 13;
    localparam int OFFS_W      = 10;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // Largest possible average: full-scale sample times 16
    localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(1023 * 16);

    localparam logic [PRESS_W-1:0] P_MAX = {1'b0, {(PRESS_W-1){1'b1}}};
    localparam logic [PRESS_W-1:0] P_MIN = {1'b1, {(PRESS_W-1){1'b0}}};

    // Pressure = mag * ref_mv * 500 / (count * slope_e7), with
    // 500 = 1e7 / (4 * 5000). Each slope ratio is reduced to KN / KD.
    localparam int NUM_K_W = 8;
    localparam int DEN_K_W = 13;

    localparam logic [NUM_K_W-1:0] KN_10KPA  = NUM_K_W'(1);
    localparam logic [DEN_K_W-1:0] KD_10KPA  = DEN_K_W'(1800);
    localparam logic [NUM_K_W-1:0] KN_100KPA = NUM_K_W'(1);
    localparam logic [DEN_K_W-1:0] KD_100KPA = DEN_K_W'(180);
    localparam logic [NUM_K_W-1:0] KN_700KPA = NUM_K_W'(250);
    localparam logic [DEN_K_W-1:0] KD_700KPA = DEN_K_W'(6429);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_MODEL  = 2'd1,
        REG_REF    = 2'd2,
        REG_OFFSET = 2'd3
    } cfg_reg_t;

    typedef enum logic [MODEL_W-1:0] {
        MODEL_10KPA  = 2'd0,
        MODEL_100KPA = 2'd1,
        MODEL_700KPA = 2'd2,
        MODEL_ALT    = 2'd3
    } model_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             full;
    } ring_stat_t;

    typedef struct packed {
        logic [MODEL_W-1:0] sensor_model;
        logic [REF_W-1:0]   ref_mv;
        logic [OFFS_W-1:0]  offset;
    } prs_cfg_t;

    function automatic logic [NUM_K_W-1:0] slope_num(input logic [MODEL_W-1:0] model);
        logic [NUM_K_W-1:0] k;
        unique case (model_t'(model)) inside
            MODEL_10KPA:            k = KN_10KPA;
            MODEL_100KPA:           k = KN_100KPA;
            MODEL_700KPA, MODEL_ALT: k = KN_700KPA;
        endcase
        return k;
    endfunction

    function automatic logic [DEN_K_W-1:0] slope_den(input logic [MODEL_W-1:0] model);
        logic [DEN_K_W-1:0] k;
        unique case (model_t'(model)) inside
            MODEL_10KPA:            k = KD_10KPA;
            MODEL_100KPA:           k = KD_100KPA;
            MODEL_700KPA, MODEL_ALT: k = KD_700KPA;
        endcase
        return k;
    endfunction

endpackage

// ----- hw/rtl/pra_ring.sv -----
// ----------------------------------------------------------------------------
// pra_ring
// Sample ring, write slot, fill count and running sum. For each beat:
// read the slot being replaced, then update sum and write the new sample.
// ----------------------------------------------------------------------------
module pra_ring (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic                          load,
    input  logic [pra_pkg::SAMPLE_W-1:0]  sample,
    input  logic [pra_pkg::WIN_W-1:0]     window_size,
    output logic                          done,
    output pra_pkg::ring_stat_t           stat
);
    import pra_pkg::*;

    logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0] old_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W:0]      sum_wide;
    logic [WIN_W-1:0]    win_eff;
    logic                was_full;
    logic                pend_reg, done_reg;

    always_comb
    begin
        if (window_size == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (window_size > WIN_W'(MAX_WINDOW))
        begin
            win_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = window_size;
        end
    end

    assign was_full = fill_reg >= win_eff;

    always_comb
    begin
        sum_wide  = {1'b0, sum_reg} + (SUM_W+1)'(smp_reg);
        fill_next = fill_reg;
        if (was_full)
        begin
            sum_wide = sum_wide - (SUM_W+1)'(old_reg);
        end
        else
        begin
            fill_next = fill_reg + 1'b1;
        end
        sum_next = sum_wide[SUM_W-1:0];

        if (WIN_W'(slot_reg) + WIN_W'(1) >= win_eff)
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            pend_reg <= load;
            done_reg <= pend_reg;
            if (restart)
            begin
                slot_reg <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end
            else if (pend_reg)
            begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
        end
    end

    // ring storage: registered read of the outgoing sample, write in the cycle after
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            old_reg <= ring_mem[slot_reg];
            smp_reg <= sample;
        end
        if (pend_reg)
        begin
            ring_mem[slot_reg] <= smp_reg;
        end
    end

    assign done       = done_reg;
    assign stat.sum   = sum_reg;
    assign stat.count = fill_reg;
    assign stat.full  = was_full;

endmodule

// ----- hw/rtl/pra_avg_div.sv -----
// ----------------------------------------------------------------------------
// pra_avg_div
// Bit-serial restoring divider: sum * 16 / count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pra_avg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  pra_pkg::ring_stat_t         stat,
    output logic                        done,
    output logic [pra_pkg::AVG_W-1:0]   average
);
    import pra_pkg::*;

    localparam int DVD_W  = SUM_W + AVG_FRAC;
    localparam int STEP_W = $clog2(AVG_W);

    logic [DVD_W-1:0]  dividend;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [AVG_W-1:0]  shf_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg;
    logic [CNT_W:0]    rem_wide, rem_sub;
    logic              fits;

    assign dividend = {stat.sum, {AVG_FRAC{1'b0}}};

    // quotient fits in AVG_W bits since sum <= 1023 * count, so the top
    // dividend bits start out below the divisor
    assign rem_wide = {rem_reg, shf_reg[AVG_W-1]};
    assign fits     = rem_wide >= {1'b0, div_reg};
    assign rem_sub  = rem_wide - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
            shf_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(AVG_W-1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                div_reg  <= stat.count;
                rem_reg  <= CNT_W'(dividend >> AVG_W);
                shf_reg  <= dividend[AVG_W-1:0];
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? rem_sub[CNT_W-1:0] : rem_wide[CNT_W-1:0];
                shf_reg  <= {shf_reg[AVG_W-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(AVG_W-1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done    = done_reg;
    assign average = shf_reg;

endmodule

// ----- hw/rtl/pra_press.sv -----
// ----------------------------------------------------------------------------
// pra_press
// Pressure scaling: signed offset removal, 2-bit-digit serial multiply by the
// reference, then a bit-serial rounding divide by count * slope with
// saturation to 19 bits.
// ----------------------------------------------------------------------------
module pra_press (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  pra_pkg::ring_stat_t                 stat,
    input  pra_pkg::prs_cfg_t                   cfg,
    output logic                                done,
    output logic signed [pra_pkg::PRESS_W-1:0]  pressure
);
    import pra_pkg::*;

    localparam int OC_W      = OFFS_W + CNT_W;
    localparam int DIFF_W    = SUM_W + 2;
    localparam int M1_W      = DIFF_W + NUM_K_W;
    localparam int M3_W      = DIFF_W + NUM_K_W + 2;
    localparam int NUM_W     = SUM_W + NUM_K_W + REF_W;
    localparam int DEN_W     = CNT_W + DEN_K_W;
    localparam int X_W       = NUM_W + 2;
    localparam int QB        = PRESS_W - 1;
    localparam int Y_W       = DEN_W + 1;
    localparam int HI_W      = X_W - QB;
    localparam int MUL_STEPS = (REF_W + 1) / 2;
    localparam int RSH_W     = 2 * MUL_STEPS;
    localparam int STEP_W    = $clog2(QB);

    typedef enum logic [2:0] {
        P_IDLE,
        P_SCALE,
        P_MUL,
        P_ROUND,
        P_DIV
    } prs_state_t;

    prs_state_t           state_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIFF_W-1:0]    diff_reg;
    logic                 neg_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [NUM_W-1:0]     m1_reg, m3_reg, acc_reg;
    logic [RSH_W-1:0]     rsh_reg;
    logic                 ovf_reg;
    logic [Y_W-1:0]       rem_reg;
    logic [QB-1:0]        qsh_reg;
    logic                 done_reg;

    logic [OC_W-1:0]      oc_prod;
    logic [DIFF_W-1:0]    diff_now;
    logic [DIFF_W-1:0]    mag;
    logic [NUM_K_W-1:0]   kn;
    logic [NUM_K_W+1:0]   kn3;
    logic [M1_W-1:0]      m1_init;
    logic [M3_W-1:0]      m3_init;
    logic [NUM_W-1:0]     digit_add;
    logic [X_W-1:0]       x_full;
    logic [HI_W-1:0]      x_hi;
    logic [Y_W-1:0]       y_val;
    logic [Y_W:0]         rem_wide, rem_sub;
    logic                 fits;
    logic [PRESS_W-1:0]   q_ext;

    assign oc_prod  = OC_W'(cfg.offset) * OC_W'(stat.count);
    assign diff_now = DIFF_W'(stat.sum) - DIFF_W'(oc_prod);
    assign mag      = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;
    assign kn       = slope_num(cfg.sensor_model);
    assign kn3      = (NUM_K_W+2)'(kn) + {1'b0, kn, 1'b0};
    assign m1_init  = M1_W'(mag) * M1_W'(kn);
    assign m3_init  = M3_W'(mag) * M3_W'(kn3);

    always_comb
    begin
        case (rsh_reg[1:0])
            2'd0:    digit_add = '0;
            2'd1:    digit_add = m1_reg;
            2'd2:    digit_add = {m1_reg[NUM_W-2:0], 1'b0};
            default: digit_add = m3_reg;
        endcase
    end

    // round to nearest: floor((2N + D) / 2D)
    assign x_full   = X_W'({acc_reg, 1'b0}) + X_W'(den_reg);
    assign x_hi     = x_full[X_W-1:QB];
    assign y_val    = {den_reg, 1'b0};
    assign rem_wide = {rem_reg, qsh_reg[QB-1]};
    assign fits     = rem_wide >= {1'b0, y_val};
    assign rem_sub  = rem_wide - {1'b0, y_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            diff_reg  <= '0;
            neg_reg   <= 1'b0;
            den_reg   <= '0;
            m1_reg    <= '0;
            m3_reg    <= '0;
            acc_reg   <= '0;
            rsh_reg   <= '0;
            ovf_reg   <= 1'b0;
            rem_reg   <= '0;
            qsh_reg   <= '0;
        end
        else
        begin
            done_reg <= (state_reg == P_DIV) && (step_reg == STEP_W'(QB-1));
            unique case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        diff_reg  <= diff_now;
                        den_reg   <= DEN_W'(stat.count) * DEN_W'(slope_den(cfg.sensor_model));
                        state_reg <= P_SCALE;
                    end
                end
                P_SCALE:
                begin
                    neg_reg   <= diff_reg[DIFF_W-1];
                    m1_reg    <= NUM_W'(m1_init);
                    m3_reg    <= NUM_W'(m3_init);
                    acc_reg   <= '0;
                    rsh_reg   <= RSH_W'(cfg.ref_mv);
                    step_reg  <= '0;
                    state_reg <= P_MUL;
                end
                P_MUL:
                begin
                    acc_reg  <= acc_reg + digit_add;
                    m1_reg   <= {m1_reg[NUM_W-3:0], 2'b00};
                    m3_reg   <= {m3_reg[NUM_W-3:0], 2'b00};
                    rsh_reg  <= {2'b00, rsh_reg[RSH_W-1:2]};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MUL_STEPS-1))
                    begin
                        state_reg <= P_ROUND;
                    end
                end
                P_ROUND:
                begin
                    // quotient of 2^18 or more saturates either sign
                    ovf_reg   <= Y_W'(x_hi) >= y_val;
                    rem_reg   <= Y_W'(x_hi);
                    qsh_reg   <= x_full[QB-1:0];
                    step_reg  <= '0;
                    state_reg <= P_DIV;
                end
                P_DIV:
                begin
                    rem_reg  <= fits ? rem_sub[Y_W-1:0] : rem_wide[Y_W-1:0];
                    qsh_reg  <= {qsh_reg[QB-2:0], fits};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(QB-1))
                    begin
                        state_reg <= P_IDLE;
                    end
                end
            endcase
        end
    end

    assign q_ext = {1'b0, qsh_reg};

    always_comb
    begin
        if (ovf_reg)
        begin
            pressure = neg_reg ? P_MIN : P_MAX;
        end
        else
        begin
            pressure = neg_reg ? (~q_ext + 1'b1) : q_ext;
        end
    end

    assign done = done_reg;

endmodule

// ----- hw/rtl/pressure_rolling_average.sv -----
// ----------------------------------------------------------------------------
// pressure_rolling_average
// Rolling-window average of converter samples with linear pressure
// calibration.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   s_      | in  | s_tvalid/s_tready  | s_tdata[9:0] sample
//   m_      | out | m_tvalid/m_tready  | m_tdata average_q, pressure_q; m_tuser
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each beat passes through the ring (read, then update) and the pressure
// unit (setup, two-bit multiply digits, rounding setup, quotient bits),
// and its results then load the output register once the output register
// is free. The average divider runs alongside (load, then quotient
// bits). A waiting result holds in the output register while the next
// sample is worked on. No clearing pass after reset; any window_size
// write restarts the window.
// ----------------------------------------------------------------------------
module pressure_rolling_average (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pra_pkg::IN_TDATA_W-1:0]    s_tdata,   // [9:0] sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pra_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [13:0] average_q, [32:14] pressure_q
    output logic                              m_tuser,   // [0] window_full
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pra_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pra_pkg::*;

    localparam int OUT_PAD_W = OUT_TDATA_W - AVG_W - PRESS_W;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t                    state_reg;
    logic                      m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg;
    logic                      m_tuser_reg;
    logic                      avg_seen_reg, prs_seen_reg;

    logic [WIN_W-1:0]          window_reg;
    prs_cfg_t                  prs_cfg_reg;

    logic                      in_beat;
    logic                      restart;
    logic                      ring_done;
    ring_stat_t                ring_stat;
    logic                      avg_done, prs_done;
    logic [AVG_W-1:0]          avg_q;
    logic signed [PRESS_W-1:0] prs_q;
    logic                      out_free;
    logic                      results_ready;
    logic                      out_load;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && (cfg_reg_t'(cfg_index) == REG_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg                <= WIN_W'(8);
            prs_cfg_reg.sensor_model  <= MODEL_100KPA;
            prs_cfg_reg.ref_mv        <= REF_W'(5000);
            prs_cfg_reg.offset        <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW: window_reg               <= cfg_data[WIN_W-1:0];
                REG_MODEL:  prs_cfg_reg.sensor_model <= cfg_data[MODEL_W-1:0];
                REG_REF:    prs_cfg_reg.ref_mv       <= cfg_data[REF_W-1:0];
                REG_OFFSET: prs_cfg_reg.offset       <= cfg_data[OFFS_W-1:0];
            endcase
        end
    end

    pra_ring u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .load        (in_beat),
        .sample      (s_tdata[SAMPLE_W-1:0]),
        .window_size (window_reg),
        .done        (ring_done),
        .stat        (ring_stat)
    );

    pra_avg_div u_avg (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ring_done),
        .stat    (ring_stat),
        .done    (avg_done),
        .average (avg_q)
    );

    pra_press u_press (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ring_done),
        .stat     (ring_stat),
        .cfg      (prs_cfg_reg),
        .done     (prs_done),
        .pressure (prs_q)
    );

    assign out_free      = !m_tvalid_reg || m_tready;
    assign results_ready = (avg_seen_reg || avg_done) && (prs_seen_reg || prs_done);
    assign out_load      = (state_reg == S_BUSY) && results_ready && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
            avg_seen_reg <= 1'b0;
            prs_seen_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        avg_seen_reg <= 1'b0;
                        prs_seen_reg <= 1'b0;
                        state_reg    <= S_BUSY;
                    end
                end
                S_BUSY:
                begin
                    if (avg_done)
                    begin
                        avg_seen_reg <= 1'b1;
                    end
                    if (prs_done)
                    begin
                        prs_seen_reg <= 1'b1;
                    end
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{OUT_PAD_W{1'b0}}, prs_q, avg_q};
                        m_tuser_reg  <= ring_stat.full;
                        state_reg    <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a sample beat always leaves the idle state
    a_beat_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input beat accepted but block still idle");

    // the ring only finishes an update for a sample that is in flight
    a_ring_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        ring_done |-> (state_reg == S_BUSY))
        else $error("ring update finished with no sample in flight");

    // average cannot exceed full-scale times 16
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[AVG_W-1:0] <= AVG_MAX))
        else $error("average out of range");

endmodule

// ----- bench/tb_pressure_rolling_average.sv -----
// ----------------------------------------------------------------------------
// tb_pressure_rolling_average
// Self-checking bench for the rolling-average pressure front end. A driver
// and a monitor run as clocked processes with random idle cycles on both
// streams. Every accepted sample updates a local window/calibration model
// whose readings are compared field by field with the output beats. Settings
// change only while the block is drained, and walk through the edge values:
// zero and oversized windows, the alternate sensor model, a zero reference
// and full-scale offsets.
// ----------------------------------------------------------------------------
module tb_pressure_rolling_average;

    timeunit 1ns;
    timeprecision 1ps;

    import pra_pkg::*;

    localparam int          N_RANDOM     = 700;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          DRAIN_CYCLES = 40;
    // full scale 1024 = 256 * 4, so one 1/256 kPa step folds in a factor of 4
    localparam longint unsigned FS_DIV       = 4;
    localparam longint unsigned SUPPLY_MV    = 5000;
    localparam longint unsigned SLOPE_UNITS  = 10000000;
    localparam longint unsigned PRESS_POS    = 2**(PRESS_W-1) - 1;
    localparam longint unsigned PRESS_NEG    = 2**(PRESS_W-1);

    typedef struct packed {
        logic [AVG_W-1:0]   average_q;
        logic [PRESS_W-1:0] pressure_q;
        logic               window_full;
    } reading_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index = REG_WINDOW;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    pressure_rolling_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Window and calibration model
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] hist [MAX_WINDOW];
    int unsigned         next_slot;
    int unsigned         held;
    int unsigned         window_sum;
    logic [WIN_W-1:0]    win_reg;
    model_t              model_reg;
    logic [REF_W-1:0]    ref_reg;
    logic [OFFS_W-1:0]   offs_reg;

    function automatic longint unsigned slope_1e7(input model_t m);
        case (m)
            MODEL_10KPA:  return 900000;
            MODEL_100KPA: return 90000;
            default:      return 12858;
        endcase
    endfunction

    function automatic void apply_setting(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_WINDOW:
            begin
                win_reg    = val[WIN_W-1:0];
                next_slot  = 0;
                held       = 0;
                window_sum = 0;
            end
            REG_MODEL:  model_reg = model_t'(val[MODEL_W-1:0]);
            REG_REF:    ref_reg   = val[REF_W-1:0];
            REG_OFFSET: offs_reg  = val[OFFS_W-1:0];
            default:    ;
        endcase
    endfunction

    function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] smp);
        int unsigned       win;
        int unsigned       slot;
        longint            diff;
        longint unsigned   mag;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   q;
        reading_t          r;
        if (win_reg == 0)
            win = 1;
        else if (win_reg > MAX_WINDOW)
            win = MAX_WINDOW;
        else
            win = win_reg;
        slot = next_slot % win;
        if (held >= win)
            window_sum -= hist[slot];
        else
            held++;
        hist[slot]  = smp;
        window_sum += smp;
        next_slot   = (slot + 1) % win;

        r.average_q = AVG_W'((window_sum * 16) / held);

        // exact sum/count average, rounded half away from zero
        diff = longint'(window_sum) - longint'(offs_reg) * longint'(held);
        mag  = (diff < 0) ? -diff : diff;
        num  = mag * longint'(ref_reg) * SLOPE_UNITS;
        den  = longint'(held) * FS_DIV * slope_1e7(model_reg) * SUPPLY_MV;
        q    = (2 * num + den) / (2 * den);
        if (diff < 0)
            r.pressure_q = (q > PRESS_NEG) ? P_MIN : PRESS_W'(-longint'(q));
        else
            r.pressure_q = (q > PRESS_POS) ? P_MAX : PRESS_W'(q);
        r.window_full = (held >= win);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sample driver
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] pending_samples [$];
    reading_t            expected_readings [$];
    int unsigned         src_gap;
    bit                  src_idle_en = 1'b1;
    bit                  snk_idle_en = 1'b1;
    int unsigned         n_sent      = 0;
    int unsigned         n_checked   = 0;
    int unsigned         n_saturated = 0;
    int unsigned         n_settings  = 0;
    int unsigned         errors      = 0;
    int unsigned         cycles      = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_readings.push_back(predict_reading(s_tdata[SAMPLE_W-1:0]));
                n_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    src_gap  <= src_gap - 1;
                end
                else if (pending_samples.size() != 0)
                begin
                    s_tdata  <= IN_TDATA_W'(pending_samples.pop_front());
                    s_tvalid <= 1'b1;
                    src_gap  <= src_idle_en ? $urandom_range(0, 4) : 0;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reading monitor
    // ------------------------------------------------------------------
    int unsigned snk_wait;
    int unsigned stall;
    reading_t    want;
    reading_t    got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            got.average_q   = m_tdata[AVG_W-1:0];
            got.pressure_q  = m_tdata[AVG_W +: PRESS_W];
            got.window_full = m_tuser;
            if (expected_readings.size() == 0)
            begin
                errors++;
                $error("reading beat with no sample outstanding: average_q %0d pressure_q %0d",
                       got.average_q, $signed(got.pressure_q));
            end
            else
            begin
                want = expected_readings.pop_front();
                if (got.average_q !== want.average_q)
                begin
                    errors++;
                    $error("average_q: expected %0d, got %0d", want.average_q, got.average_q);
                end
                if (got.pressure_q !== want.pressure_q)
                begin
                    errors++;
                    $error("pressure_q: expected %0d, got %0d",
                           $signed(want.pressure_q), $signed(got.pressure_q));
                end
                if (got.window_full !== want.window_full)
                begin
                    errors++;
                    $error("window_full: expected %0d, got %0d",
                           want.window_full, got.window_full);
                end
                n_checked++;
                if (want.pressure_q == P_MAX || want.pressure_q == P_MIN)
                    n_saturated++;
            end
            stall = snk_idle_en ? $urandom_range(0, 4) : 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                snk_wait <= stall - 1;
            end
        end
        else if (!m_tready)
        begin
            if (snk_wait == 0)
                m_tready <= 1'b1;
            else
                snk_wait <= snk_wait - 1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("[pressure_rolling_average] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] stage [$];

    task automatic write_setting(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_setting(idx, val);
        n_settings++;
        cfg_valid <= 1'b0;
    endtask

    // hand the staged samples to the driver, then wait until fully drained
    task automatic play();
        @(negedge clk);
        foreach (stage[i])
            pending_samples.push_back(stage[i]);
        stage.delete();
        while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_settings();
        int unsigned pick;
        if ($urandom_range(0, 4) < 3)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_setting(REG_WINDOW, CFG_DATA_W'($urandom_range(0, 63)));
            else if (pick < 5)
                write_setting(REG_WINDOW, CFG_DATA_W'($urandom_range(1, 4)));
            else
                write_setting(REG_WINDOW, CFG_DATA_W'($urandom_range(1, MAX_WINDOW)));
        end
        if ($urandom_range(0, 1))
            write_setting(REG_MODEL, CFG_DATA_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1))
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:       write_setting(REG_REF, '0);
                1:       write_setting(REG_REF, '1);
                2:       write_setting(REG_REF, CFG_DATA_W'(5500));
                3:       write_setting(REG_REF, CFG_DATA_W'(1));
                4:       write_setting(REG_REF, CFG_DATA_W'($urandom_range(0, 8191)));
                default: write_setting(REG_REF, CFG_DATA_W'($urandom_range(1, 5500)));
            endcase
        end
        if ($urandom_range(0, 1))
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                write_setting(REG_OFFSET, '0);
            else if (pick == 1)
                write_setting(REG_OFFSET, CFG_DATA_W'(1023));
            else
                write_setting(REG_OFFSET, CFG_DATA_W'($urandom_range(0, 1023)));
        end
    endtask

    initial
    begin
        int unsigned len;
        int unsigned kind;
        int          base;
        int          v;

        win_reg    = 8;
        model_reg  = MODEL_100KPA;
        ref_reg    = 5000;
        offs_reg   = 0;
        next_slot  = 0;
        held       = 0;
        window_sum = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: fill the 8-deep window and wrap past it
        stage = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1023, 10'd1023,
                  10'd1023, 10'd1023, 10'd1023, 10'd1};
        play();

        // zero window acts as one; alternate model; large offset goes negative
        write_setting(REG_WINDOW, '0);
        write_setting(REG_MODEL, CFG_DATA_W'(MODEL_ALT));
        write_setting(REG_REF, '1);
        write_setting(REG_OFFSET, CFG_DATA_W'(1023));
        stage = '{10'd0, 10'd1023, 10'd512};
        play();

        // oversized window clamps to the maximum; positive saturation
        write_setting(REG_WINDOW, CFG_DATA_W'(63));
        write_setting(REG_MODEL, CFG_DATA_W'(MODEL_700KPA));
        write_setting(REG_OFFSET, '0);
        stage = '{10'd1023, 10'd1023, 10'd1000, 10'd0};
        play();

        // zero reference gives zero pressure
        write_setting(REG_WINDOW, CFG_DATA_W'(MAX_WINDOW));
        write_setting(REG_MODEL, CFG_DATA_W'(MODEL_10KPA));
        write_setting(REG_REF, '0);
        write_setting(REG_OFFSET, CFG_DATA_W'(512));
        stage = '{10'd0, 10'd1023, 10'd700};
        play();

        len = n_sent + N_RANDOM;
        while (n_sent < len)
        begin
            random_settings();
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 3);
            base = $urandom_range(0, 1023);
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(60, 90)
                                                : $urandom_range(8, 40))
            begin
                case (kind)
                    0: v = $urandom_range(0, 1023);
                    1: v = $urandom_range(0, 1) ? 1023 : 0;
                    2: v = int'(offs_reg) + $urandom_range(0, 6) - 3;
                    default: v = base + $urandom_range(0, 16) - 8;
                endcase
                if (v < 0)
                    v = 0;
                if (v > 1023)
                    v = 1023;
                stage.push_back(SAMPLE_W'(v));
            end
            play();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_readings.size() != 0)
        begin
            errors++;
            $error("%0d readings never arrived", expected_readings.size());
        end
        $display("Sent %0d samples across %0d register writes; checked %0d readings",
                 n_sent, n_settings, n_checked);
        $display("(%0d at a saturation limit), with random stalls on both streams",
                 n_saturated);
        if (errors == 0)
            $display("[pressure_rolling_average] OK");
        else
            $display("[pressure_rolling_average] ERROR");
        $finish;
    end

endmodule
